[src/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// shared types and constants for the block bitmap allocator
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    // map geometry
    localparam int MAX_BLOCKS = 65536;
    localparam int WORD_BITS  = 32;
    localparam int MAP_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;

    localparam int IDX_W      = $clog2(WORD_BITS);
    localparam int ADDR_W     = $clog2(MAP_WORDS);
    localparam int NW_W       = ADDR_W + 1;
    localparam int CNT_W      = 17;
    localparam int BLKNUM_W   = 16;
    localparam int REG_IDX_W  = 1;

    // reset values of the counters and registers
    localparam logic [CNT_W-1:0] RESET_FREE     = CNT_W'(65536);
    localparam logic [CNT_W-1:0] RESET_TOTAL    = CNT_W'(65536);
    localparam logic [CNT_W-1:0] RESET_RESERVED = '0;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_TOTAL    = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_RESERVED = REG_IDX_W'(1);

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_TEST   = 2'd2,
        OP_FORMAT = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NO_FREE      = 2'd1,
        ST_RANGE        = 2'd2,
        ST_ALREADY_FREE = 2'd3
    } status_t;

endpackage

`default_nettype wire

[src/bba_if.sv]
// ----------------------------------------------------------------------------
// bba_if
// request, response and register write channels of the allocator
// ----------------------------------------------------------------------------
`default_nettype none

interface bba_req_if;
    import bba_pkg::*;

    logic                valid;
    logic                ready;
    opcode_t             operation;
    logic [BLKNUM_W-1:0] block_number;

    modport source (output valid, output operation, output block_number, input ready);
    modport sink   (input valid, input operation, input block_number, output ready);
endinterface

interface bba_rsp_if;
    import bba_pkg::*;

    logic                valid;
    logic                ready;
    status_t             status;
    logic [BLKNUM_W-1:0] block_number_res;
    logic                bit_value;
    logic [CNT_W-1:0]    free_count;

    modport source (output valid, output status, output block_number_res,
                    output bit_value, output free_count, input ready);
    modport sink   (input valid, input status, input block_number_res,
                    input bit_value, input free_count, output ready);
endinterface

interface bba_cfg_if;
    import bba_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] reg_index;
    logic [CNT_W-1:0]     wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

[src/block_bitmap_allocator.sv]
// ----------------------------------------------------------------------------
// block_bitmap_allocator
// free-block bitmap with first-fit allocate, free, test and format
// free and test read the named word, then test or clear the bit; rejected
//   ops go straight to the result; allocate scans from the first word until
//   one has a clear bit; format writes every map word, one map word per cycle
// one transaction in flight, the next one is taken the cycle after the result
//   moves to the output register
// after reset a clearing pass writes all MAP_WORDS words, req
//   not ready meanwhile; register writes are taken at any time
// ----------------------------------------------------------------------------
`default_nettype none

module block_bitmap_allocator (
    input  wire logic clk,
    input  wire logic rst_n,
    bba_req_if.sink   req,
    bba_rsp_if.source rsp,
    bba_cfg_if.sink   cfg
);
    import bba_pkg::*;

    // sequencer states, one-hot
    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,  // clearing pass after reset
        S_IDLE   = 7'b0000010,  // waiting for a request
        S_SCAN   = 7'b0000100,  // first-fit word scan
        S_LOOK   = 7'b0001000,  // read the word of the named block
        S_CHECK  = 7'b0010000,  // test or clear the named bit
        S_FORMAT = 7'b0100000,  // rewrite the whole map
        S_DONE   = 7'b1000000   // hand the result to the output register
    } state_t;

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    state_t               state_reg,     state_next;
    logic [CNT_W-1:0]     total_reg,     total_next;
    logic [CNT_W-1:0]     reserved_reg,  reserved_next;
    logic [CNT_W-1:0]     free_reg,      free_next;

    // scan pipeline: scan_w issues reads, chk_w names the word in rd_data
    logic [NW_W-1:0]      scan_w_reg,    scan_w_next;
    logic [ADDR_W-1:0]    chk_w_reg,     chk_w_next;
    logic                 chk_vld_reg,   chk_vld_next;

    // format / clear sweep
    logic [ADDR_W-1:0]    sweep_w_reg,   sweep_w_next;
    logic [NW_W-1:0]      fmt_full_reg,  fmt_full_next;
    logic [IDX_W-1:0]     fmt_rem_reg,   fmt_rem_next;

    // the request being worked on
    opcode_t              op_reg,        op_next;
    logic [BLKNUM_W-1:0]  blk_reg,       blk_next;

    // pending result
    status_t              res_status_reg, res_status_next;
    logic [BLKNUM_W-1:0]  res_blk_reg,    res_blk_next;
    logic                 res_bit_reg,    res_bit_next;

    // output register
    logic                 out_valid_reg,  out_valid_next;
    status_t              out_status_reg, out_status_next;
    logic [BLKNUM_W-1:0]  out_blk_reg,    out_blk_next;
    logic                 out_bit_reg,    out_bit_next;
    logic [CNT_W-1:0]     out_free_reg,   out_free_next;

    // ------------------------------------------------------------------------
    // map memory, one write and one registered read per cycle
    // ------------------------------------------------------------------------
    logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    // lowest clear bit of a word
    function automatic logic [IDX_W-1:0] first_zero(input logic [WORD_BITS-1:0] word);
        logic [IDX_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!word[i])
            begin
                pos = IDX_W'(i);
            end
        end
        return pos;
    endfunction

    // ------------------------------------------------------------------------
    // derived values
    // ------------------------------------------------------------------------
    logic [CNT_W-1:0]     eff_total;     // total clamped to the map size
    logic [CNT_W:0]       nw_sum;
    logic [NW_W-1:0]      num_words;     // words covering the managed blocks
    logic [CNT_W-1:0]     resv;          // reserved clamped to the total
    logic [IDX_W-1:0]     zero_pos;
    logic [BLKNUM_W-1:0]  cand;          // first-fit candidate block
    logic                 chk_full;
    logic                 chk_last;
    logic                 blk_bit;
    logic [WORD_BITS-1:0] blk_mask;
    logic [WORD_BITS-1:0] fmt_word;
    logic                 out_load;

    assign eff_total = (total_reg > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : total_reg;
    assign nw_sum    = (CNT_W + 1)'(eff_total) + (CNT_W + 1)'(WORD_BITS - 1);
    assign num_words = NW_W'(nw_sum >> IDX_W);
    assign resv      = (reserved_reg > eff_total) ? eff_total : reserved_reg;

    assign zero_pos  = first_zero(rd_data_reg);
    assign cand      = {chk_w_reg, zero_pos};
    assign chk_full  = (rd_data_reg == '1);
    assign chk_last  = ((NW_W'(chk_w_reg) + NW_W'(1)) == num_words);

    assign blk_mask  = WORD_BITS'(1) << blk_reg[IDX_W-1:0];
    assign blk_bit   = |(rd_data_reg & blk_mask);

    // words below the reserved boundary are all ones, the boundary word is
    // partly set, the rest is cleared
    always_comb
    begin
        if (NW_W'(sweep_w_reg) < fmt_full_reg)
        begin
            fmt_word = '1;
        end
        else if (NW_W'(sweep_w_reg) == fmt_full_reg)
        begin
            fmt_word = (WORD_BITS'(1) << fmt_rem_reg) - WORD_BITS'(1);
        end
        else
        begin
            fmt_word = '0;
        end
    end

    // result moves into the output register when it is empty or being drained
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        total_next      = total_reg;
        reserved_next   = reserved_reg;
        free_next       = free_reg;
        scan_w_next     = scan_w_reg;
        chk_w_next      = chk_w_reg;
        chk_vld_next    = chk_vld_reg;
        sweep_w_next    = sweep_w_reg;
        fmt_full_next   = fmt_full_reg;
        fmt_rem_next    = fmt_rem_reg;
        op_next         = op_reg;
        blk_next        = blk_reg;
        res_status_next = res_status_reg;
        res_blk_next    = res_blk_reg;
        res_bit_next    = res_bit_reg;

        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;

        // register writes
        if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                REG_TOTAL:    total_next    = cfg.wr_data;
                REG_RESERVED: reserved_next = cfg.wr_data;
                default:      ;
            endcase
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = sweep_w_reg;
                wr_data      = fmt_word;
                sweep_w_next = sweep_w_reg + ADDR_W'(1);
                if (sweep_w_reg == ADDR_W'(MAP_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next  = req.operation;
                    blk_next = req.block_number;
                    unique case (req.operation)
                        OP_ALLOC:
                        begin
                            res_blk_next = '0;
                            res_bit_next = 1'b0;
                            if ((free_reg == '0) || (num_words == '0))
                            begin
                                res_status_next = ST_NO_FREE;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                scan_w_next  = '0;
                                chk_vld_next = 1'b0;
                                state_next   = S_SCAN;
                            end
                        end

                        OP_FREE, OP_TEST:
                        begin
                            res_blk_next = req.block_number;
                            res_bit_next = 1'b0;
                            if (CNT_W'(req.block_number) >= eff_total)
                            begin
                                res_status_next = ST_RANGE;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_LOOK;
                            end
                        end

                        OP_FORMAT:
                        begin
                            fmt_full_next   = NW_W'(resv >> IDX_W);
                            fmt_rem_next    = resv[IDX_W-1:0];
                            sweep_w_next    = '0;
                            free_next       = eff_total - resv;
                            res_status_next = ST_OK;
                            res_blk_next    = '0;
                            res_bit_next    = 1'b0;
                            state_next      = S_FORMAT;
                        end

                        default: ;
                    endcase
                end
            end

            S_SCAN:
            begin
                // issue the next word while the previous one is checked
                rd_en   = (scan_w_reg < num_words);
                rd_addr = scan_w_reg[ADDR_W-1:0];

                if (chk_vld_reg && !chk_full)
                begin
                    if (CNT_W'(cand) < eff_total)
                    begin
                        wr_en           = 1'b1;
                        wr_addr         = chk_w_reg;
                        wr_data         = rd_data_reg | (WORD_BITS'(1) << zero_pos);
                        free_next       = free_reg - CNT_W'(1);
                        res_status_next = ST_OK;
                        res_blk_next    = cand;
                        res_bit_next    = 1'b1;
                    end
                    else
                    begin
                        // clear bit lies past the total
                        res_status_next = ST_NO_FREE;
                    end
                    state_next = S_DONE;
                end
                else if (chk_vld_reg && chk_last)
                begin
                    // every covered word is full: count out of step with map
                    res_status_next = ST_NO_FREE;
                    state_next      = S_DONE;
                end
                else
                begin
                    chk_vld_next = rd_en;
                    chk_w_next   = scan_w_reg[ADDR_W-1:0];
                    if (rd_en)
                    begin
                        scan_w_next = scan_w_reg + NW_W'(1);
                    end
                end
            end

            S_LOOK:
            begin
                rd_en      = 1'b1;
                rd_addr    = blk_reg[BLKNUM_W-1:IDX_W];
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                state_next = S_DONE;
                if (op_reg == OP_TEST)
                begin
                    res_status_next = ST_OK;
                    res_bit_next    = blk_bit;
                end
                else if (!blk_bit)
                begin
                    res_status_next = ST_ALREADY_FREE;
                end
                else
                begin
                    wr_en           = 1'b1;
                    wr_addr         = blk_reg[BLKNUM_W-1:IDX_W];
                    wr_data         = rd_data_reg & ~blk_mask;
                    res_status_next = ST_OK;
                    if (free_reg < eff_total)
                    begin
                        free_next = free_reg + CNT_W'(1);
                    end
                end
            end

            S_FORMAT:
            begin
                wr_en        = 1'b1;
                wr_addr      = sweep_w_reg;
                wr_data      = fmt_word;
                sweep_w_next = sweep_w_reg + ADDR_W'(1);
                if (sweep_w_reg == ADDR_W'(MAP_WORDS - 1))
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_blk_next    = out_blk_reg;
        out_bit_next    = out_bit_reg;
        out_free_next   = out_free_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_blk_next    = res_blk_reg;
            out_bit_next    = res_bit_reg;
            out_free_next   = free_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            total_reg     <= RESET_TOTAL;
            reserved_reg  <= RESET_RESERVED;
            free_reg      <= RESET_FREE;
            scan_w_reg    <= '0;
            chk_vld_reg   <= 1'b0;
            sweep_w_reg   <= '0;
            fmt_full_reg  <= '0;
            fmt_rem_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            reserved_reg  <= reserved_next;
            free_reg      <= free_next;
            scan_w_reg    <= scan_w_next;
            chk_vld_reg   <= chk_vld_next;
            sweep_w_reg   <= sweep_w_next;
            fmt_full_reg  <= fmt_full_next;
            fmt_rem_reg   <= fmt_rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        chk_w_reg      <= chk_w_next;
        op_reg         <= op_next;
        blk_reg        <= blk_next;
        res_status_reg <= res_status_next;
        res_blk_reg    <= res_blk_next;
        res_bit_reg    <= res_bit_next;
        out_status_reg <= out_status_next;
        out_blk_reg    <= out_blk_next;
        out_bit_reg    <= out_bit_next;
        out_free_reg   <= out_free_next;
    end

    // ports
    assign req.ready            = (state_reg == S_IDLE);
    assign cfg.ready            = 1'b1;
    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = out_status_reg;
    assign rsp.block_number_res = out_blk_reg;
    assign rsp.bit_value        = out_bit_reg;
    assign rsp.free_count       = out_free_reg;

endmodule

`default_nettype wire

[src/bba_checker.sv]
// ----------------------------------------------------------------------------
// bba_checker
// port-level checks of the block bitmap allocator
// ----------------------------------------------------------------------------
`default_nettype none

module bba_checker (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   req_valid,
    input wire logic                   req_ready,
    input wire logic                   rsp_valid,
    input wire logic                   rsp_ready,
    input wire bba_pkg::status_t       rsp_status,
    input wire logic [bba_pkg::BLKNUM_W-1:0] rsp_block_number_res,
    input wire logic                   rsp_bit_value,
    input wire logic [bba_pkg::CNT_W-1:0]    rsp_free_count
);
    import bba_pkg::*;

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_block_number_res) && $stable(rsp_bit_value)
            && $stable(rsp_free_count))
        else $error("response changed while stalled");

    // one transaction at a time
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // failed allocation names no block
    a_no_free_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_NO_FREE)
            |-> (rsp_block_number_res == '0) && !rsp_bit_value)
        else $error("failed allocation reports a block");

    // rejected free or test reports a clear bit
    a_reject_bit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ((rsp_status == ST_RANGE) || (rsp_status == ST_ALREADY_FREE))
            |-> !rsp_bit_value)
        else $error("rejected request reports a set bit");

    // free count never exceeds the map
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_free_count <= CNT_W'(MAX_BLOCKS))
        else $error("free count above map size");

endmodule

bind block_bitmap_allocator bba_checker u_bba_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .req_valid            (req.valid),
    .req_ready            (req.ready),
    .rsp_valid            (rsp.valid),
    .rsp_ready            (rsp.ready),
    .rsp_status           (rsp.status),
    .rsp_block_number_res (rsp.block_number_res),
    .rsp_bit_value        (rsp.bit_value),
    .rsp_free_count       (rsp.free_count)
);

`default_nettype wire

[verif/block_bitmap_allocator_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_bitmap_allocator_checker
// watches the request, response and register channels of the allocator,
// keeps its own copy of the used map and free count, predicts every response
// and compares it field by field with what the block returns
// ----------------------------------------------------------------------------

module block_bitmap_allocator_checker (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bba_req_if          req,
    bba_rsp_if          rsp,
    bba_cfg_if          cfg,
    output int unsigned awaiting,
    output int unsigned mismatches
);
    import bba_pkg::*;

    typedef struct packed {
        status_t             status;
        logic [BLKNUM_W-1:0] blk;
        logic                used;
        logic [CNT_W-1:0]    count;
    } alloc_result_t;

    logic [WORD_BITS-1:0] block_used [MAP_WORDS];
    logic [CNT_W-1:0]     free_left;
    logic [CNT_W-1:0]     reg_total;
    logic [CNT_W-1:0]     reg_reserved;

    alloc_result_t        expected_results [$];
    alloc_result_t        want;
    int unsigned          results_seen;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // blocks actually managed, a total above the map size is clipped
    function automatic int managed_blocks();
        return (int'(reg_total) > MAX_BLOCKS) ? MAX_BLOCKS : int'(reg_total);
    endfunction

    // updates the map copy and returns the response the block should give
    function automatic alloc_result_t apply_request(input opcode_t op,
                                                    input logic [BLKNUM_W-1:0] blk);
        alloc_result_t        r;
        int                   total;
        int                   nwords;
        int                   w;
        int                   b;
        int                   i;
        int                   cand;
        int                   resv;
        int                   n;
        logic                 done;
        logic [WORD_BITS-1:0] word;

        total    = managed_blocks();
        n        = int'(blk);
        r.status = ST_OK;
        r.blk    = '0;
        r.used   = 1'b0;
        case (op)
            OP_ALLOC:
            begin
                if (free_left != '0)
                begin
                    nwords = (total + WORD_BITS - 1) / WORD_BITS;
                    done   = 1'b0;
                    for (w = 0; w < nwords && !done; w++)
                    begin
                        word = block_used[w];
                        if (word != '1)
                        begin
                            // first word with a clear bit ends the search
                            done = 1'b1;
                            b    = WORD_BITS - 1;
                            for (i = WORD_BITS - 1; i >= 0; i--)
                                if (!word[i])
                                    b = i;
                            cand = w * WORD_BITS + b;
                            if (cand < total)
                            begin
                                block_used[w][b] = 1'b1;
                                free_left        = free_left - 1'b1;
                                r.blk            = BLKNUM_W'(cand);
                                r.used           = 1'b1;
                            end
                        end
                    end
                end
                if (!r.used)
                    r.status = ST_NO_FREE;
            end
            OP_FREE:
            begin
                r.blk = blk;
                if (n >= total)
                    r.status = ST_RANGE;
                else if (!block_used[n / WORD_BITS][n % WORD_BITS])
                    r.status = ST_ALREADY_FREE;
                else
                begin
                    block_used[n / WORD_BITS][n % WORD_BITS] = 1'b0;
                    if (int'(free_left) < total)
                        free_left = free_left + 1'b1;
                end
            end
            OP_TEST:
            begin
                r.blk = blk;
                if (n >= total)
                    r.status = ST_RANGE;
                else
                    r.used = block_used[n / WORD_BITS][n % WORD_BITS];
            end
            default:
            begin
                resv = (int'(reg_reserved) > total) ? total : int'(reg_reserved);
                for (w = 0; w < MAP_WORDS; w++)
                begin
                    word = '1;
                    if ((w + 1) * WORD_BITS <= resv)
                        block_used[w] = word;
                    else if (w * WORD_BITS < resv)
                        block_used[w] = word >> (WORD_BITS - (resv - w * WORD_BITS));
                    else
                        block_used[w] = '0;
                end
                free_left = CNT_W'(total - resv);
            end
        endcase
        r.count = free_left;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < MAP_WORDS; w++)
                block_used[w] = '0;
            free_left    = RESET_FREE;
            reg_total    = RESET_TOTAL;
            reg_reserved = RESET_RESERVED;
            expected_results.delete();
            results_seen = 0;
            mismatches   = 0;
            awaiting    <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.reg_index == REG_TOTAL)
                    reg_total = cfg.wr_data;
                else if (cfg.reg_index == REG_RESERVED)
                    reg_reserved = cfg.wr_data;
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("response %0d with no request waiting",
                                              results_seen));
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch($sformatf("response %0d status got %0d want %0d",
                                                  results_seen, rsp.status, want.status));
                    if (rsp.block_number_res !== want.blk)
                        report_mismatch($sformatf("response %0d block got %0d want %0d",
                                                  results_seen, rsp.block_number_res,
                                                  want.blk));
                    if (rsp.bit_value !== want.used)
                        report_mismatch($sformatf("response %0d bit got %0b want %0b",
                                                  results_seen, rsp.bit_value, want.used));
                    if (rsp.free_count !== want.count)
                        report_mismatch($sformatf("response %0d free count got %0d want %0d",
                                                  results_seen, rsp.free_count, want.count));
                end
                results_seen++;
            end
            if (req.valid && req.ready)
                expected_results.push_back(apply_request(req.operation, req.block_number));
            awaiting <= expected_results.size();
        end
    end

endmodule

[verif/block_bitmap_allocator_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_bitmap_allocator_tb
// drives the allocator with a directed sequence and then randomized phases
// under several map sizes, with random idling on both sides and one long
// response hold-off; a checker beside the block predicts every response
// ----------------------------------------------------------------------------

module block_bitmap_allocator_tb;
    import bba_pkg::*;

    localparam int PHASES       = 12;
    localparam int STEADY_PHASE = 6;        // phase run with no idling at all
    localparam int HOLD_PHASE   = 3;        // phase that gets the long hold-off
    localparam int HOLD_AT      = 50;       // item of that phase that starts it
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 2100;     // longer than a full map scan
    localparam int RUN_LIMIT    = 2000000;

    logic clk = 1'b0;
    logic rst_n;

    // stimulus shaping flags, written only with nonblocking assignments
    logic steady   = 1'b0;
    logic hold_go  = 1'b0;
    logic rsp_hold = 1'b0;

    int unsigned outstanding;
    int unsigned mismatch_count;
    int unsigned cycle_count = 0;

    // bookkeeping for the closing summary
    int op_count [4] = '{0, 0, 0, 0};
    int reg_writes   = 0;
    int settings     = 1;

    // phase table: total, reserved, whether the phase opens with a format, items
    int ph_total  [PHASES] = '{64, 200, 1, 1024, 40, 0, 131071, 65536, 500, 96, 300, 777};
    int ph_resv   [PHASES] = '{0, 13, 0, 100, 7, 5, 0, 65500, 600, 96, 31, 0};
    int ph_format [PHASES] = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 1, 0};
    int ph_items  [PHASES] = '{150, 150, 60, 240, 150, 40, 150, 12, 120, 100, 150, 200};

    bba_req_if req_ch ();
    bba_rsp_if rsp_ch ();
    bba_cfg_if cfg_ch ();

    block_bitmap_allocator DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    block_bitmap_allocator_checker u_alloc_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .cfg        (cfg_ch),
        .awaiting   (outstanding),
        .mismatches (mismatch_count)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit, far above the slowest legal run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, outstanding);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // response side: random back-pressure, none in the steady stretch,
    // forced low while the hold-off runs
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_hold)
                rsp_ch.ready <= 1'b0;
            else if (steady)
                rsp_ch.ready <= 1'b1;
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= 26);
        end
    end

    // long hold-off, counted here so the sender keeps offering meanwhile
    initial
    begin
        do
            @(posedge clk);
        while (!hold_go);
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_hold <= 1'b0;
    end

    // one request transaction; valid is left high so a back-to-back
    // transaction never lowers and raises it in the same step
    task automatic send_request(input opcode_t op, input logic [BLKNUM_W-1:0] blk);
        if (!steady)
        begin
            while ($urandom_range(0, 99) < 26)
            begin
                req_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        req_ch.valid        <= 1'b1;
        req_ch.operation    <= op;
        req_ch.block_number <= blk;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        op_count[op]++;
    endtask

    // drop valid and wait until every response has come back
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // both registers in two back-to-back transactions, block must be idle
    task automatic write_regs(input int total, input int resv);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= REG_TOTAL;
        cfg_ch.wr_data   <= CNT_W'(total);
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.reg_index <= REG_RESERVED;
        cfg_ch.wr_data   <= CNT_W'(resv);
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        reg_writes   += 2;
        settings++;
    endtask

    initial
    begin
        int                  t;
        int                  hot;
        int                  pick;
        opcode_t             op;
        logic [BLKNUM_W-1:0] blk;

        req_ch.valid        <= 1'b0;
        req_ch.operation    <= OP_ALLOC;
        req_ch.block_number <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.reg_index    <= REG_TOTAL;
        cfg_ch.wr_data      <= '0;
        rst_n               <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: full map, both ends of the block range, double free
        send_request(OP_TEST, '0);
        send_request(OP_TEST, '1);
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE, '0);
        send_request(OP_FREE, '0);
        send_request(OP_FREE, '1);

        // shrink to one block without format: free count out of step with
        // the map, allocate fails on a full map, free stops at the total
        settle();
        write_regs(1, 0);
        send_request(OP_ALLOC, 16'h5a5a);
        send_request(OP_ALLOC, '0);
        send_request(OP_TEST, 16'd1);
        send_request(OP_FREE, '0);

        // reserved above total: format leaves nothing free
        settle();
        write_regs(40, 100);
        send_request(OP_FORMAT, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_TEST, 16'd39);
        send_request(OP_FREE, 16'd39);
        send_request(OP_ALLOC, '0);

        // lowest clear bit sits at the total: allocate fails with a nonzero count
        settle();
        write_regs(40, 39);
        send_request(OP_FORMAT, '0);
        settle();
        write_regs(39, 39);
        send_request(OP_ALLOC, '0);
        settle();
        write_regs(40, 39);
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '0);

        // total above the map size, only the very last block free: longest scan
        settle();
        write_regs(17'h1ffff, 65535);
        send_request(OP_FORMAT, '1);
        send_request(OP_ALLOC, '0);
        send_request(OP_TEST, '1);
        send_request(OP_FREE, '1);

        // zero total with all-ones reserved
        settle();
        write_regs(0, 17'h1ffff);
        send_request(OP_FORMAT, '0);
        send_request(OP_TEST, '0);
        send_request(OP_ALLOC, '0);

        // random phases, most open with a format so allocations get deep
        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            steady <= (ph == STEADY_PHASE);
            write_regs(ph_total[ph], ph_resv[ph]);
            t   = (ph_total[ph] > MAX_BLOCKS) ? MAX_BLOCKS : ph_total[ph];
            // used blocks gather at the low end, so frees aim there often
            hot = (ph_resv[ph] + 64 < t) ? ph_resv[ph] + 64 : t;
            if (ph_format[ph] != 0)
                send_request(OP_FORMAT, BLKNUM_W'($urandom));
            for (int n = 0; n < ph_items[ph]; n++)
            begin
                if (ph == HOLD_PHASE && n == HOLD_AT)
                    hold_go <= 1'b1;
                // mix: rare format, then allocate, free and test
                pick = $urandom_range(0, 199);
                if (pick < 3)
                    op = OP_FORMAT;
                else if (pick < 83)
                    op = OP_ALLOC;
                else if (pick < 143)
                    op = OP_FREE;
                else
                    op = OP_TEST;
                // block: wide noise, the used low end, or anywhere in range
                pick = $urandom_range(0, 99);
                if (t == 0 || pick < 8)
                    blk = BLKNUM_W'($urandom);
                else if (pick < 55)
                    blk = BLKNUM_W'($urandom_range(0, hot - 1));
                else
                    blk = BLKNUM_W'($urandom_range(0, t - 1));
                send_request(op, blk);
            end
        end

        // drain, then give any stray response time to show up
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d requests: %0d allocate, %0d free, %0d test, %0d format",
                 op_count[OP_ALLOC] + op_count[OP_FREE] + op_count[OP_TEST]
                 + op_count[OP_FORMAT], op_count[OP_ALLOC], op_count[OP_FREE],
                 op_count[OP_TEST], op_count[OP_FORMAT]);
        $display("over %0d register settings (%0d register writes) and one long hold-off",
                 settings, reg_writes);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
